[hdl/ttrs_pkg.sv]
package ttrs_pkg;

	localparam int TAG_LENGTH = 4;
	localparam int HOLD_DEPTH = TAG_LENGTH + 1;
	localparam int CMD_BYTES = TAG_LENGTH + 2;
	localparam int CMD_NW = $clog2(CMD_BYTES + 1);
	localparam int CMD_IW = $clog2(CMD_BYTES);
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int OUT_FIFO_DEPTH = 2;
	localparam int COUNT_WIDTH_DEFAULT = 16;
	localparam int CAP_WIDTH = 16;
	localparam logic [CAP_WIDTH-1:0] CAP_RESET = 16'd256;

	localparam logic [7:0] CH_LT = 8'h3c;
	localparam logic [7:0] CH_GT = 8'h3e;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} text_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} result_t;

	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] bytes;
		logic [CMD_NW-1:0]         n;
		logic                      last;
	} cmd_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR;
	endfunction

	// tag 0 is "tool", tag 1 is "args"; zero past the name
	function automatic logic [7:0] tag_letter(input logic tag, input logic [2:0] pos);
		logic [7:0] r;
		case ({tag, pos})
			4'b0_000: r = 8'h74;
			4'b0_001: r = 8'h6f;
			4'b0_010: r = 8'h6f;
			4'b0_011: r = 8'h6c;
			4'b1_000: r = 8'h61;
			4'b1_001: r = 8'h72;
			4'b1_010: r = 8'h67;
			4'b1_011: r = 8'h73;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[hdl/ttrs_front.sv]
module ttrs_front #(
	parameter int COUNT_WIDTH = ttrs_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ttrs_pkg::CAP_WIDTH-1:0] cfg_data,
	input  logic                           accept,
	input  ttrs_pkg::text_t                text,
	output logic                           cmd_write,
	output ttrs_pkg::cmd_t                 cmd
);
	import ttrs_pkg::*;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'd0,
		MODE_OPEN  = 2'd1,
		MODE_CLOSE = 2'd2
	} mode_t;

	localparam int LW = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;
	localparam int HCW = $clog2(HOLD_DEPTH + 1);
	localparam int HIW = $clog2(HOLD_DEPTH);
	localparam int PW = $clog2(TAG_LENGTH + 3);

	logic [7:0]             held_q [HOLD_DEPTH];
	logic [7:0]             held_nx [HOLD_DEPTH];
	logic [HCW-1:0]         held_cnt_q, held_cnt_nx;
	mode_t                  mode_q, mode_nx;
	logic                   tag_q, tag_nx;
	logic [PW-1:0]          prog_q, prog_nx;
	logic [COUNT_WIDTH-1:0] count_q, count_nx;
	logic [CAP_WIDTH-1:0]   cap_q;

	logic [CAP_WIDTH-1:0]   cap_m1;
	logic [LW-1:0]          cap_ext, max_ext, lim_ext;
	logic [COUNT_WIDTH-1:0] lim, avail;

	logic [7:0]        b, lb, x_byte;
	logic              last, ok, fresh, x_en;
	logic [HCW-1:0]    rel_h;
	logic [CMD_NW-1:0] n_total, take;

	assign cfg_ready = 1'b1;
	assign b = text.in_byte;
	assign last = text.in_last;
	assign lb = to_lower(b);

	assign cap_m1 = (cap_q == '0) ? '0 : cap_q - 1'b1;
	assign cap_ext = LW'(cap_m1);
	assign max_ext = LW'({COUNT_WIDTH{1'b1}});
	assign lim_ext = (cap_ext > max_ext) ? max_ext : cap_ext;
	assign lim = lim_ext[COUNT_WIDTH-1:0];
	assign avail = (count_q < lim) ? lim - count_q : '0;

	always_comb begin
		held_nx = held_q;
		held_cnt_nx = held_cnt_q;
		mode_nx = mode_q;
		tag_nx = tag_q;
		prog_nx = prog_q;
		rel_h = '0;
		x_en = 1'b0;
		x_byte = b;
		fresh = 1'b0;
		ok = 1'b0;
		case (mode_q)
			MODE_OPEN: begin
				if (b == CH_GT) begin
					mode_nx = MODE_CLOSE;
					prog_nx = '0;
				end
			end
			MODE_CLOSE: begin
				if (prog_q == '0) begin
					ok = (b == CH_LT);
				end else if (prog_q == PW'(1)) begin
					ok = (b == CH_SLASH);
				end else if (prog_q < PW'(TAG_LENGTH + 2)) begin
					ok = (lb == tag_letter(tag_q, 3'(prog_q - PW'(2))));
				end else begin
					ok = (b == CH_GT);
				end
				if (!ok) begin
					prog_nx = (b == CH_LT) ? PW'(1) : '0;
				end else if (prog_q >= PW'(TAG_LENGTH + 2)) begin
					mode_nx = MODE_PASS;
					prog_nx = '0;
				end else begin
					prog_nx = prog_q + 1'b1;
				end
			end
			default: begin
				if (held_cnt_q == '0) begin
					fresh = 1'b1;
				end else if (held_cnt_q <= HCW'(TAG_LENGTH)) begin
					if (held_cnt_q == HCW'(1)) begin
						if (lb == tag_letter(1'b0, 3'd0)) begin
							tag_nx = 1'b0;
							ok = 1'b1;
						end else if (lb == tag_letter(1'b1, 3'd0)) begin
							tag_nx = 1'b1;
							ok = 1'b1;
						end
					end else begin
						ok = (lb == tag_letter(tag_q, 3'(held_cnt_q - 1'b1)));
					end
					if (ok) begin
						if (last) begin
							rel_h = held_cnt_q;
							x_en = 1'b1;
						end else begin
							held_nx[held_cnt_q[HIW-1:0]] = b;
							held_cnt_nx = held_cnt_q + 1'b1;
						end
					end else begin
						rel_h = held_cnt_q;
						fresh = 1'b1;
					end
				end else if (b == CH_GT || b == CH_SP || b == CH_TAB) begin
					held_cnt_nx = '0;
					prog_nx = '0;
					mode_nx = (b == CH_GT) ? MODE_CLOSE : MODE_OPEN;
					x_en = 1'b1;
					x_byte = CH_SP;
				end else begin
					rel_h = held_cnt_q;
					fresh = 1'b1;
				end
				if (fresh) begin
					held_cnt_nx = '0;
					if (b != CH_LT || last) begin
						x_en = 1'b1;
					end else if (avail > COUNT_WIDTH'(rel_h)) begin
						held_nx[0] = b;
						held_cnt_nx = HCW'(1);
					end
				end
			end
		endcase

		n_total = CMD_NW'(rel_h) + CMD_NW'(x_en);
		take = (avail < COUNT_WIDTH'(n_total)) ? CMD_NW'(avail) : n_total;

		if (last) begin
			held_cnt_nx = '0;
			mode_nx = MODE_PASS;
			tag_nx = 1'b0;
			prog_nx = '0;
			count_nx = '0;
		end else begin
			count_nx = count_q + COUNT_WIDTH'(take);
		end
	end

	always_comb begin
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			cmd.bytes[i] = (HCW'(i) < rel_h) ? held_q[i] : x_byte;
		end
		cmd.bytes[CMD_BYTES-1] = x_byte;
		cmd.n = take;
		cmd.last = last;
	end

	assign cmd_write = accept && (take != '0 || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= '0;
			mode_q <= MODE_PASS;
			tag_q <= 1'b0;
			prog_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			held_cnt_q <= held_cnt_nx;
			mode_q <= mode_nx;
			tag_q <= tag_nx;
			prog_q <= prog_nx;
			count_q <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_nx;
		end
	end

	a_prog_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_CLOSE |-> prog_q == '0)
		else $error("close progress set outside close search");

	a_hold_pass: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q != '0 |-> mode_q == MODE_PASS && held_cnt_q <= HCW'(HOLD_DEPTH))
		else $error("bytes held outside passing mode");

	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.in_last |=> held_cnt_q == '0 && mode_q == MODE_PASS && count_q == '0)
		else $error("stream state not cleared after final item");

	a_cmd_size: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_write |-> cmd.n <= CMD_NW'(CMD_BYTES))
		else $error("command longer than its byte slots");

endmodule

[hdl/ttrs_cmd_fifo.sv]
module ttrs_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  ttrs_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output ttrs_pkg::cmd_t rdata,
	output logic           empty
);
	import ttrs_pkg::*;

	localparam int PW = $clog2(CMD_FIFO_DEPTH);
	localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

	cmd_t          mem_q [CMD_FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full = (cnt_q == CW'(CMD_FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[hdl/ttrs_back.sv]
module ttrs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ttrs_pkg::cmd_t    cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output ttrs_pkg::result_t result,
	output logic              empty,
	input  logic              pop
);
	import ttrs_pkg::*;

	localparam int OPW = $clog2(OUT_FIFO_DEPTH);
	localparam int OCW = $clog2(OUT_FIFO_DEPTH + 1);

	result_t           ob_q [OUT_FIFO_DEPTH];
	logic [OPW-1:0]    ob_wr_q, ob_rd_q;
	logic [OCW-1:0]    ob_cnt_q;
	logic              ob_full, wr, rd;

	logic [CMD_IW-1:0]    idx_q;
	logic                 sp_q, as_q, sp_nx, as_nx;
	logic [CMD_BYTES-1:0] nonws;
	logic                 any_nonws, later_nonws, last_idx;
	logic [7:0]           c;
	logic                 emit, done, fin, go;
	result_t              res;

	always_comb begin
		later_nonws = 1'b0;
		for (int j = 0; j < CMD_BYTES; j++) begin
			nonws[j] = (CMD_NW'(j) < cmd.n) && !is_ws(cmd.bytes[j]);
			if (CMD_IW'(j) > idx_q) begin
				later_nonws = later_nonws | nonws[j];
			end
		end
	end

	assign any_nonws = |nonws;
	assign c = cmd.bytes[idx_q];
	assign last_idx = (CMD_NW'(idx_q) == CMD_NW'(cmd.n - 1'b1));

	always_comb begin
		emit = 1'b0;
		done = 1'b0;
		sp_nx = sp_q;
		as_nx = as_q;
		res = '0;
		res.out_last = 1'b1;
		if (cmd.n == '0) begin
			emit = cmd.last;
			done = 1'b1;
		end else if (is_ws(c)) begin
			if (!as_q) begin
				sp_nx = 1'b1;
				as_nx = 1'b1;
			end
			done = 1'b1;
			emit = last_idx && cmd.last && !any_nonws;
		end else if (sp_q) begin
			emit = 1'b1;
			res.out_byte = CH_SP;
			res.out_valid = 1'b1;
			res.out_last = 1'b0;
			sp_nx = 1'b0;
		end else begin
			emit = 1'b1;
			res.out_byte = c;
			res.out_valid = 1'b1;
			res.out_last = cmd.last && !later_nonws;
			as_nx = 1'b0;
			done = 1'b1;
		end
	end

	assign fin = done && (last_idx || cmd.n == '0);
	assign go = !cmd_empty && !(emit && ob_full);
	assign cmd_pop = go && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sp_q <= 1'b0;
			as_q <= 1'b1;
		end else if (go) begin
			if (fin && cmd.last) begin
				sp_q <= 1'b0;
				as_q <= 1'b1;
			end else begin
				sp_q <= sp_nx;
				as_q <= as_nx;
			end
			if (fin) begin
				idx_q <= '0;
			end else if (done) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign ob_full = (ob_cnt_q == OCW'(OUT_FIFO_DEPTH));
	assign empty = (ob_cnt_q == '0);
	assign wr = go && emit;
	assign rd = pop && !empty;
	assign result = ob_q[ob_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q <= '0;
			ob_rd_q <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (wr) begin
				ob_wr_q <= (ob_wr_q == OPW'(OUT_FIFO_DEPTH - 1)) ? '0 : ob_wr_q + 1'b1;
			end
			if (rd) begin
				ob_rd_q <= (ob_rd_q == OPW'(OUT_FIFO_DEPTH - 1)) ? '0 : ob_rd_q + 1'b1;
			end
			if (wr && !rd) begin
				ob_cnt_q <= ob_cnt_q + 1'b1;
			end else if (rd && !wr) begin
				ob_cnt_q <= ob_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ob_q[ob_wr_q] <= res;
		end
	end

	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q <= OCW'(OUT_FIFO_DEPTH))
		else $error("result buffer overflow");

	a_pending_space: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q |-> as_q)
		else $error("pending space without whitespace state");

	a_last_reset: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.last |=> as_q && !sp_q && idx_q == '0)
		else $error("collapse state not reset after final item");

	a_marker_retire: assert property (@(posedge clk) disable iff (!arst_n)
		wr && !res.out_valid |-> cmd_pop && res.out_last)
		else $error("end marker does not close its item");

endmodule

[hdl/tool_tag_region_scrubber.sv]
// Path: command queue, then back end into the result buffer feeding the result ports.
// Throughput: one item per cycle while each item yields at most one result and full is
// low; the back end takes released bytes and inserted spaces one at a time, so a release
// burst of up to six bytes is absorbed by the two-entry command queue.
// Reset: arst_n asynchronous, active low; clears stream state, queues, capacity to 256.
module tool_tag_region_scrubber #(
	parameter int COUNT_WIDTH = ttrs_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ttrs_pkg::CAP_WIDTH-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  ttrs_pkg::text_t                text,
	output logic                           empty,
	input  logic                           pop,
	output ttrs_pkg::result_t              result
);
	import ttrs_pkg::*;

	logic accept;
	logic cmd_write, cmd_full, cmd_empty, cmd_pop;
	cmd_t cmd_in, cmd_out;

	assign full = cmd_full;
	assign accept = push && !cmd_full;

	ttrs_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.text      (text),
		.cmd_write (cmd_write),
		.cmd       (cmd_in)
	);

	ttrs_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_write),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	ttrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

[verif/tool_tag_region_scrubber_test.sv]
`timescale 1ns / 1ps

module tool_tag_region_scrubber_test;

	import ttrs_pkg::*;

	typedef enum logic [1:0] {PASSING, SEEK_GT, SEEK_CLOSE} scrub_e;
	typedef enum logic {ROW_TEXT, ROW_CAP} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic [15:0] value;
		logic        last;
		logic        typed;
		result_t     want;
	} row_t;

	localparam int MAX_OUT = TAG_LENGTH + 3;
	localparam int SETTLE_CYCLES = 12;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_ITEMS = 55;
	localparam int TX_IDLE [3] = '{37, 50, 0};
	localparam int RX_IDLE [3] = '{50, 37, 0};
	localparam logic [15:0] PHASE_CAP [3] = '{16'd256, 16'd12, 16'hffff};

	localparam result_t NONE = '0;
	localparam result_t MARKER = '{8'h00, 1'b0, 1'b1};

	localparam row_t SCRIPT [30] = '{
		'{ROW_TEXT, 16'h0000, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{ROW_TEXT, 16'h00ff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1}},
		'{ROW_TEXT, CH_TAB,   1'b1, 1'b1, MARKER},
		'{ROW_TEXT, CH_LT,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "A",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "r",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "G",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "s",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, CH_SP,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "Z",      1'b1, 1'b0, NONE},
		'{ROW_TEXT, CH_LT,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "t",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "O",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "o",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "L",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "x",      1'b1, 1'b0, NONE},
		'{ROW_CAP,  16'd1,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "q",      1'b1, 1'b1, MARKER},
		'{ROW_CAP,  16'd0,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "q",      1'b1, 1'b1, MARKER},
		'{ROW_CAP,  16'd3,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "a",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "b",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "c",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "d",      1'b1, 1'b0, NONE},
		'{ROW_CAP,  16'hffff, 1'b0, 1'b0, NONE},
		'{ROW_TEXT, "m",      1'b0, 1'b0, NONE},
		'{ROW_TEXT, "n",      1'b0, 1'b0, NONE},
		'{ROW_CAP,  16'd2,    1'b0, 1'b0, NONE},
		'{ROW_TEXT, "o",      1'b1, 1'b0, NONE}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        push;
	logic        full;
	text_t       text;
	logic        empty;
	logic        pop;
	result_t     result;

	tool_tag_region_scrubber i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.text      (text),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	// predictor state
	logic [15:0] cap_q = 16'd256;
	logic [7:0]  held [HOLD_DEPTH];
	int          held_n = 0;
	scrub_e      mode = PASSING;
	bit          which = 1'b0;
	int          close_at = 0;
	int          fp_count = 0;
	bit          sp_pend = 1'b0;
	bit          aft_sp = 1'b1;

	result_t     step_out [$];
	result_t     scrubbed_q [$];
	logic [7:0]  txt [$];

	int          tx_idle = 0;
	int          rx_idle = 0;
	bit          hold_armed = 1'b0;
	logic        cur_typed = 1'b0;
	result_t     cur_want = '0;

	int          errors = 0;
	int          stuck = 0;
	int          n_bytes = 0;
	int          n_texts = 0;
	int          n_checked = 0;
	int          opened = 0;
	int          closed = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] fold(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] name_char(input bit t, input int p);
		logic [31:0] word;
		word = t ? "args" : "tool";
		return (p < 4) ? word[31 - 8 * p -: 8] : 8'h00;
	endfunction

	function automatic void add_out(input logic [7:0] b, input logic v);
		if (step_out.size() < MAX_OUT)
			step_out.push_back('{out_byte: b, out_valid: v, out_last: 1'b0});
	endfunction

	function automatic void squeeze(input logic [7:0] b);
		if (b == CH_SP || b == CH_TAB || b == CH_LF || b == CH_CR) begin
			if (!aft_sp) begin
				sp_pend = 1'b1;
				aft_sp = 1'b1;
			end
		end else begin
			if (sp_pend)
				add_out(CH_SP, 1'b1);
			add_out(b, 1'b1);
			sp_pend = 1'b0;
			aft_sp = 1'b0;
		end
	endfunction

	function automatic int budget();
		return (cap_q == 16'd0) ? 0 : int'(cap_q) - 1;
	endfunction

	function automatic void put_first(input logic [7:0] b);
		if (fp_count < budget()) begin
			fp_count++;
			squeeze(b);
		end
	endfunction

	function automatic void take_fresh(input logic [7:0] b);
		if (fp_count >= budget())
			return;
		if (b == CH_LT) begin
			held[0] = b;
			held_n = 1;
		end else begin
			put_first(b);
		end
	endfunction

	function automatic void flush_held();
		for (int k = 0; k < held_n; k++)
			put_first(held[k]);
		held_n = 0;
	endfunction

	function automatic void scan_plain(input logic [7:0] b);
		logic ok;
		if (held_n == 0) begin
			take_fresh(b);
			return;
		end
		if (held_n <= TAG_LENGTH) begin
			if (held_n == 1) begin
				ok = 1'b1;
				if (fold(b) == name_char(1'b0, 0))
					which = 1'b0;
				else if (fold(b) == name_char(1'b1, 0))
					which = 1'b1;
				else
					ok = 1'b0;
			end else begin
				ok = fold(b) == name_char(which, held_n - 1);
			end
			if (ok) begin
				held[held_n] = b;
				held_n++;
				return;
			end
		end else if (b == CH_GT || b == CH_SP || b == CH_TAB) begin
			held_n = 0;
			close_at = 0;
			mode = (b == CH_GT) ? SEEK_CLOSE : SEEK_GT;
			opened++;
			put_first(CH_SP);
			return;
		end
		flush_held();
		take_fresh(b);
	endfunction

	function automatic void seek_close(input logic [7:0] b);
		logic ok;
		if (close_at == 0)
			ok = b == CH_LT;
		else if (close_at == 1)
			ok = b == CH_SLASH;
		else if (close_at < TAG_LENGTH + 2)
			ok = fold(b) == name_char(which, close_at - 2);
		else
			ok = b == CH_GT;
		if (!ok) begin
			close_at = (b == CH_LT) ? 1 : 0;
		end else if (close_at >= TAG_LENGTH + 2) begin
			mode = PASSING;
			close_at = 0;
			closed++;
		end else begin
			close_at++;
		end
	endfunction

	function automatic void predict_scrub(input logic [7:0] b, input logic last,
			input logic typed, input result_t want);
		result_t tail;
		step_out.delete();
		case (mode)
			SEEK_GT: begin
				if (b == CH_GT) begin
					mode = SEEK_CLOSE;
					close_at = 0;
				end
			end
			SEEK_CLOSE: seek_close(b);
			default: scan_plain(b);
		endcase
		if (last) begin
			if (mode == PASSING)
				flush_held();
			if (step_out.size() == 0)
				add_out(8'h00, 1'b0);
			tail = step_out.pop_back();
			tail.out_last = 1'b1;
			step_out.push_back(tail);
			held_n = 0;
			mode = PASSING;
			which = 1'b0;
			close_at = 0;
			fp_count = 0;
			sp_pend = 1'b0;
			aft_sp = 1'b1;
		end
		if (typed) begin
			step_out.delete();
			step_out.push_back(want);
		end
		foreach (step_out[k])
			scrubbed_q.push_back(step_out[k]);
	endfunction

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				cap_q = cfg_data;
			if (push && !full) begin
				predict_scrub(text.in_byte, text.in_last, cur_typed, cur_want);
				if (text.in_last)
					n_texts++;
			end
			if (pop && !empty) begin
				n_checked++;
				if (scrubbed_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected item: byte %02h valid %b last %b",
							result.out_byte, result.out_valid, result.out_last);
				end else begin
					want = scrubbed_q.pop_front();
					if (result.out_byte !== want.out_byte || result.out_valid !== want.out_valid
							|| result.out_last !== want.out_last) begin
						errors++;
						if (errors <= 10)
							$display("item %0d: expected %02h/%b/%b, got %02h/%b/%b", n_checked,
								want.out_byte, want.out_valid, want.out_last,
								result.out_byte, result.out_valid, result.out_last);
					end
				end
			end
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
		end
	end

	initial begin
		wait (stuck >= STUCK_LIMIT);
		$display("no progress for %0d cycles", STUCK_LIMIT);
		$display("tool_tag_region_scrubber: mismatch");
		$finish;
	end

	initial begin : receiver
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop <= ($urandom_range(99, 0) >= rx_idle);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
			input result_t want);
		while ($urandom_range(99, 0) < tx_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		text <= '{in_byte: b, in_last: last};
		cur_typed = typed;
		cur_want = want;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n_bytes++;
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (scrubbed_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = 8'($urandom_range(122, 97));
		return $urandom_range(1, 0) ? c - 8'd32 : c;
	endfunction

	function automatic void put_word(input int n);
		repeat (n) txt.push_back(rand_letter());
	endfunction

	function automatic void put_name(input bit t, input int n);
		logic [7:0] c;
		for (int p = 0; p < n; p++) begin
			c = name_char(t, p);
			txt.push_back($urandom_range(1, 0) ? c - 8'd32 : c);
		end
	endfunction

	function automatic void compose_text();
		int k;
		int n;
		bit t;
		txt.delete();
		repeat ($urandom_range(6, 1)) begin
			k = $urandom_range(99, 0);
			if (k < 40) begin
				t = $urandom_range(1, 0);
				txt.push_back(CH_LT);
				put_name(t, TAG_LENGTH);
				n = $urandom_range(9, 0);
				if (n < 6) begin
					txt.push_back(CH_GT);
				end else if (n < 9) begin
					txt.push_back(n == 6 ? CH_SP : CH_TAB);
					put_word($urandom_range(4, 0));
					txt.push_back(CH_GT);
				end
				put_word($urandom_range(5, 0));
				if ($urandom_range(3, 0) == 0)
					txt.push_back(CH_LT);
				n = $urandom_range(9, 0);
				if (n < 8) begin
					txt.push_back(CH_LT);
					txt.push_back(CH_SLASH);
					put_name(n == 7 ? !t : t, TAG_LENGTH);
					txt.push_back(CH_GT);
				end else if (n == 8) begin
					txt.push_back(CH_LT);
					txt.push_back(CH_SLASH);
					put_name(t, $urandom_range(3, 0));
				end
			end else if (k < 62) begin
				put_word($urandom_range(6, 1));
			end else if (k < 77) begin
				repeat ($urandom_range(3, 1)) begin
					case ($urandom_range(3, 0))
						0: txt.push_back(CH_SP);
						1: txt.push_back(CH_TAB);
						2: txt.push_back(CH_LF);
						default: txt.push_back(CH_CR);
					endcase
				end
			end else if (k < 89) begin
				txt.push_back(CH_LT);
				put_name($urandom_range(1, 0), $urandom_range(TAG_LENGTH, 0));
				txt.push_back($urandom_range(1, 0) ? rand_letter() : 8'($urandom_range(255, 0)));
			end else begin
				repeat ($urandom_range(3, 1)) txt.push_back(8'($urandom_range(255, 0)));
			end
		end
	endfunction

	initial begin : stimulus
		int sent;
		arst_n = 1'b0;
		push = 1'b0;
		text = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		tx_idle = TX_IDLE[0];
		rx_idle = RX_IDLE[0];
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_CAP)
				set_capacity(SCRIPT[i].value);
			else
				send_item(SCRIPT[i].value[7:0], SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
		end

		for (int p = 0; p < 3; p++) begin
			tx_idle = TX_IDLE[p];
			rx_idle = RX_IDLE[p];
			set_capacity(PHASE_CAP[p]);
			if (p == 2)
				hold_armed = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				compose_text();
				foreach (txt[j])
					send_item(txt[j], j == txt.size() - 1, 1'b0, NONE);
				sent += txt.size();
			end
		end

		settle();
		$display("%0d bytes in %0d texts gave %0d result items; %0d tag regions opened, %0d closed",
			n_bytes, n_texts, n_checked, opened, closed);
		$display("capacities 0 to 3, 12, 256 and 65535 applied; %0d items differed", errors);
		if (errors == 0 && scrubbed_q.size() == 0)
			$display("tool_tag_region_scrubber: match");
		else
			$display("tool_tag_region_scrubber: mismatch");
		$finish;
	end

endmodule
